[rtl/core/crp_pkg.sv]
// ----------------------------------------------------------------------------
// crp_pkg: controller report parser shared types and constants
// Byte offsets, length thresholds, button masks and the packet record that
// travels from the front end through the queue to the decoder.
// ----------------------------------------------------------------------------
package crp_pkg;

   // Byte counter width; the counter saturates at its all-ones value
   localparam int COUNT_W = 7;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 7'd127;

   // Byte offsets within the report
   localparam logic [COUNT_W-1:0] BTN_FIRST   = 7'h03;
   localparam logic [COUNT_W-1:0] BTN_LAST    = 7'h06;
   localparam logic [COUNT_W-1:0] STICK_FIRST = 7'h0A;
   localparam logic [COUNT_W-1:0] STICK_LAST  = 7'h0F;
   localparam logic [COUNT_W-1:0] MOT_FIRST   = 7'h10;
   localparam logic [COUNT_W-1:0] MOT_LAST    = 7'h13;
   localparam logic [COUNT_W-1:0] DIST_FIRST  = 7'h16;
   localparam logic [COUNT_W-1:0] DIST_LAST   = 7'h17;
   localparam logic [COUNT_W-1:0] TRIG_FIRST  = 7'h3C;
   localparam logic [COUNT_W-1:0] TRIG_LAST   = 7'h3D;

   // Packet lengths needed before a field is taken from the packet
   localparam logic [COUNT_W-1:0] MIN_LEN    = 7'd7;
   localparam logic [COUNT_W-1:0] LSTICK_LEN = 7'd13;
   localparam logic [COUNT_W-1:0] RSTICK_LEN = 7'd16;
   localparam logic [COUNT_W-1:0] MX_LEN     = 7'd18;
   localparam logic [COUNT_W-1:0] MY_LEN     = 7'd20;
   localparam logic [COUNT_W-1:0] MD_LEN     = 7'd24;

   localparam logic [11:0] STICK_DEFAULT = 12'd2047;

   // Button groups that reveal which hand holds the controller
   localparam logic [31:0] RIGHT_HAND_BTNS = 32'h0000FF00 | 32'h00040000 | 32'h00020000 |
                                             32'h00100000 | 32'h00400000;
   localparam logic [31:0] LEFT_HAND_BTNS  = 32'hFF000000 | 32'h00080000 | 32'h00010000 |
                                             32'h00200000;

   // Hand hint codes
   localparam logic [1:0] HINT_LEFT  = 2'd1;
   localparam logic [1:0] HINT_RIGHT = 2'd2;

   // Captured packet, one entry per final byte
   typedef struct packed {
      logic [COUNT_W-1:0] len;
      logic [31:0]        buttons;
      logic [15:0]        triggers;
      logic [47:0]        sticks;
      logic [47:0]        motion;
   } pkt_type;

endpackage

[rtl/core/crp_front.sv]
// ----------------------------------------------------------------------------
// crp_front: byte capture front end
// Counts bytes of the current packet, captures the bytes at the report's
// offsets and pushes one packet record into the queue on the final byte.
// ----------------------------------------------------------------------------
module crp_front #(
   parameter int MAX_PACKET_BYTES = 96
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [7:0]       req_byte_in,
   input  logic             req_last_byte,
   output logic             push,
   output crp_pkg::pkt_type push_data,
   input  logic             push_ready
);

   localparam logic [crp_pkg::COUNT_W:0] MAX_LEN = (crp_pkg::COUNT_W + 1)'(MAX_PACKET_BYTES);

   logic [crp_pkg::COUNT_W-1:0] count_ff, count_in;
   logic [31:0]                 buttons_ff, buttons_in;
   logic [15:0]                 triggers_ff, triggers_in;
   logic [47:0]                 sticks_ff, sticks_in;
   logic [47:0]                 motion_ff, motion_in;
   logic [crp_pkg::COUNT_W:0]   pos_inc;
   logic [crp_pkg::COUNT_W-1:0] len;
   logic                        take;

   // Item taken whenever the queue has room for a possible record
   assign req_ready = push_ready;
   assign take      = req_valid && req_ready;
   assign push      = take && req_last_byte;

   // Byte capture at the report offsets
   always_comb begin
      buttons_in  = buttons_ff;
      triggers_in = triggers_ff;
      sticks_in   = sticks_ff;
      motion_in   = motion_ff;
      if ({1'b0, count_ff} < MAX_LEN) begin
         case (count_ff) inside
            [crp_pkg::BTN_FIRST:crp_pkg::BTN_LAST]: begin
               buttons_in[{2'(count_ff - crp_pkg::BTN_FIRST), 3'b000} +: 8] = req_byte_in;
            end
            [crp_pkg::TRIG_FIRST:crp_pkg::TRIG_LAST]: begin
               triggers_in[{1'(count_ff - crp_pkg::TRIG_FIRST), 3'b000} +: 8] = req_byte_in;
            end
            [crp_pkg::STICK_FIRST:crp_pkg::STICK_LAST]: begin
               sticks_in[{3'(count_ff - crp_pkg::STICK_FIRST), 3'b000} +: 8] = req_byte_in;
            end
            [crp_pkg::MOT_FIRST:crp_pkg::MOT_LAST]: begin
               motion_in[{3'(count_ff - crp_pkg::MOT_FIRST), 3'b000} +: 8] = req_byte_in;
            end
            [crp_pkg::DIST_FIRST:crp_pkg::DIST_LAST]: begin
               motion_in[{3'(count_ff - crp_pkg::DIST_FIRST) + 3'd4, 3'b000} +: 8] =
                  req_byte_in;
            end
            default: begin
            end
         endcase
      end
   end

   // Packet length including the final byte, limited to the packet maximum
   assign pos_inc = {1'b0, count_ff} + 1'b1;
   assign len     = (pos_inc > MAX_LEN) ? MAX_LEN[crp_pkg::COUNT_W-1:0]
                                        : pos_inc[crp_pkg::COUNT_W-1:0];

   // Saturating counter, cleared after the final byte
   always_comb begin
      count_in = count_ff;
      if (take) begin
         if (req_last_byte) begin
            count_in = '0;
         end else if (count_ff != crp_pkg::COUNT_MAX) begin
            count_in = pos_inc[crp_pkg::COUNT_W-1:0];
         end
      end
   end

   always_comb begin
      push_data.len      = len;
      push_data.buttons  = buttons_in;
      push_data.triggers = triggers_in;
      push_data.sticks   = sticks_in;
      push_data.motion   = motion_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // Captured bytes; every field read later is rewritten in its own packet
   always_ff @(posedge clock) begin
      if (take) begin
         buttons_ff  <= buttons_in;
         triggers_ff <= triggers_in;
         sticks_ff   <= sticks_in;
         motion_ff   <= motion_in;
      end
   end

endmodule

[rtl/core/crp_queue.sv]
// ----------------------------------------------------------------------------
// crp_queue: two-entry packet queue
// Decouples the byte front end from the report decoder.
// ----------------------------------------------------------------------------
module crp_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  crp_pkg::pkt_type push_data,
   output logic             push_ready,
   output logic             pop_valid,
   input  logic             pop,
   output crp_pkg::pkt_type pop_data
);

   crp_pkg::pkt_type mem_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       fill_ff, fill_in;
   logic             do_push, do_pop;

   assign push_ready = (fill_ff != 2'd2);
   assign pop_valid  = (fill_ff != 2'd0);
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;
   assign pop_data   = mem_ff[rd_ptr_ff];

   // Pointer and fill bookkeeping
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      fill_in   = fill_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[rtl/core/crp_back.sv]
// ----------------------------------------------------------------------------
// crp_back: report decoder
// Turns a packet record into the decoded report fields, applying defaults
// for fields whose bytes did not arrive, and holds them in an output register.
// ----------------------------------------------------------------------------
module crp_back (
   input  logic                clock,
   input  logic                reset,
   input  logic [1:0]          side_hint,
   input  logic                pop_valid,
   output logic                pop,
   input  crp_pkg::pkt_type    pop_data,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_report_valid,
   output logic [31:0]         rsp_buttons,
   output logic [7:0]          rsp_trigger_left,
   output logic [7:0]          rsp_trigger_right,
   output logic [11:0]         rsp_left_stick_x,
   output logic [11:0]         rsp_left_stick_y,
   output logic [11:0]         rsp_right_stick_x,
   output logic [11:0]         rsp_right_stick_y,
   output logic signed [15:0]  rsp_motion_x,
   output logic signed [15:0]  rsp_motion_y,
   output logic signed [15:0]  rsp_motion_distance,
   output logic [1:0]          rsp_hand_mask
);

   logic               valid_ff, valid_in;
   logic               rv_ff, rv_in;
   logic [31:0]        btn_ff, btn_in;
   logic [7:0]         tl_ff, tl_in;
   logic [7:0]         tr_ff, tr_in;
   logic [11:0]        lx_ff, lx_in;
   logic [11:0]        ly_ff, ly_in;
   logic [11:0]        rx_ff, rx_in;
   logic [11:0]        ry_ff, ry_in;
   logic [15:0]        mx_ff, mx_in;
   logic [15:0]        my_ff, my_in;
   logic [15:0]        md_ff, md_in;
   logic [1:0]         hand_ff, hand_in;
   logic [crp_pkg::COUNT_W-1:0] len;

   // Load a new item when the output register is empty or being drained
   assign pop = pop_valid && (!valid_ff || rsp_ready);
   assign len = pop_data.len;

   // Field decode with defaults
   always_comb begin
      rv_in   = 1'b0;
      btn_in  = '0;
      tl_in   = '0;
      tr_in   = '0;
      lx_in   = '0;
      ly_in   = '0;
      rx_in   = '0;
      ry_in   = '0;
      mx_in   = '0;
      my_in   = '0;
      md_in   = '0;
      hand_in = '0;
      if (len >= crp_pkg::MIN_LEN) begin
         rv_in  = 1'b1;
         btn_in = pop_data.buttons;
         lx_in  = crp_pkg::STICK_DEFAULT;
         ly_in  = crp_pkg::STICK_DEFAULT;
         rx_in  = crp_pkg::STICK_DEFAULT;
         ry_in  = crp_pkg::STICK_DEFAULT;
         if (len > crp_pkg::TRIG_FIRST) begin
            tl_in = pop_data.triggers[7:0];
         end
         if (len > crp_pkg::TRIG_LAST) begin
            tr_in = pop_data.triggers[15:8];
         end
         if (len >= crp_pkg::LSTICK_LEN) begin
            lx_in = pop_data.sticks[11:0];
            ly_in = pop_data.sticks[23:12];
         end
         if (len >= crp_pkg::RSTICK_LEN) begin
            rx_in = pop_data.sticks[35:24];
            ry_in = pop_data.sticks[47:36];
         end
         if (len >= crp_pkg::MX_LEN) begin
            mx_in = pop_data.motion[15:0];
         end
         if (len >= crp_pkg::MY_LEN) begin
            my_in = pop_data.motion[31:16];
         end
         if (len >= crp_pkg::MD_LEN) begin
            md_in = pop_data.motion[47:32];
         end
         hand_in[0] = (side_hint == crp_pkg::HINT_LEFT) ||
                      ((pop_data.buttons & crp_pkg::LEFT_HAND_BTNS) != '0);
         hand_in[1] = (side_hint == crp_pkg::HINT_RIGHT) ||
                      ((pop_data.buttons & crp_pkg::RIGHT_HAND_BTNS) != '0);
      end
   end

   // Output valid
   always_comb begin
      valid_in = valid_ff;
      if (pop) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Output payload
   always_ff @(posedge clock) begin
      if (pop) begin
         rv_ff   <= rv_in;
         btn_ff  <= btn_in;
         tl_ff   <= tl_in;
         tr_ff   <= tr_in;
         lx_ff   <= lx_in;
         ly_ff   <= ly_in;
         rx_ff   <= rx_in;
         ry_ff   <= ry_in;
         mx_ff   <= mx_in;
         my_ff   <= my_in;
         md_ff   <= md_in;
         hand_ff <= hand_in;
      end
   end

   assign rsp_valid           = valid_ff;
   assign rsp_report_valid    = rv_ff;
   assign rsp_buttons         = btn_ff;
   assign rsp_trigger_left    = tl_ff;
   assign rsp_trigger_right   = tr_ff;
   assign rsp_left_stick_x    = lx_ff;
   assign rsp_left_stick_y    = ly_ff;
   assign rsp_right_stick_x   = rx_ff;
   assign rsp_right_stick_y   = ry_ff;
   assign rsp_motion_x        = signed'(mx_ff);
   assign rsp_motion_y        = signed'(my_ff);
   assign rsp_motion_distance = signed'(md_ff);
   assign rsp_hand_mask       = hand_ff;

endmodule

[rtl/core/controller_report_parser_core.sv]
// A report's packet record is written into the queue when its final byte is
// accepted, and moves into the output register once that register is free.
// Throughput: one byte per cycle while the queue has room, and the decoder
// emits one report per cycle while the output is taken. Input stalls only
// while the two-entry queue is full behind a held output.
// Reset: synchronous, active high; clears the byte counter, queue, output
// valid and the side hint register.
// ----------------------------------------------------------------------------
// controller_report_parser_core: game controller report parser
// Byte capture front end, two-entry packet queue and report decoder with an
// output register; holds the hand hint register.
// ----------------------------------------------------------------------------
module controller_report_parser_core #(
   parameter int MAX_PACKET_BYTES = 96
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_en,
   input  logic [1:0]         csr_write_data,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [7:0]         req_byte_in,
   input  logic               req_last_byte,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic               rsp_report_valid,
   output logic [31:0]        rsp_buttons,
   output logic [7:0]         rsp_trigger_left,
   output logic [7:0]         rsp_trigger_right,
   output logic [11:0]        rsp_left_stick_x,
   output logic [11:0]        rsp_left_stick_y,
   output logic [11:0]        rsp_right_stick_x,
   output logic [11:0]        rsp_right_stick_y,
   output logic signed [15:0] rsp_motion_x,
   output logic signed [15:0] rsp_motion_y,
   output logic signed [15:0] rsp_motion_distance,
   output logic [1:0]         rsp_hand_mask
);

   logic [1:0]       side_hint_ff, side_hint_in;
   logic             push, push_ready, pop, pop_valid;
   crp_pkg::pkt_type push_data, pop_data;

   // Hand hint register
   assign side_hint_in = csr_write_en ? csr_write_data : side_hint_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         side_hint_ff <= 2'd0;
      end else begin
         side_hint_ff <= side_hint_in;
      end
   end

   crp_front #(
      .MAX_PACKET_BYTES (MAX_PACKET_BYTES)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_byte_in   (req_byte_in),
      .req_last_byte (req_last_byte),
      .push          (push),
      .push_data     (push_data),
      .push_ready    (push_ready)
   );

   crp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop        (pop),
      .pop_data   (pop_data)
   );

   crp_back u_back (
      .clock               (clock),
      .reset               (reset),
      .side_hint           (side_hint_ff),
      .pop_valid           (pop_valid),
      .pop                 (pop),
      .pop_data            (pop_data),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_report_valid    (rsp_report_valid),
      .rsp_buttons         (rsp_buttons),
      .rsp_trigger_left    (rsp_trigger_left),
      .rsp_trigger_right   (rsp_trigger_right),
      .rsp_left_stick_x    (rsp_left_stick_x),
      .rsp_left_stick_y    (rsp_left_stick_y),
      .rsp_right_stick_x   (rsp_right_stick_x),
      .rsp_right_stick_y   (rsp_right_stick_y),
      .rsp_motion_x        (rsp_motion_x),
      .rsp_motion_y        (rsp_motion_y),
      .rsp_motion_distance (rsp_motion_distance),
      .rsp_hand_mask       (rsp_hand_mask)
   );

endmodule

[test/tb_controller_report_parser_core.sv]
// ----------------------------------------------------------------------------
// tb_controller_report_parser_core: report parser byte-stream testbench
// Streams controller report packets one byte per item, predicts each decoded
// report in a scoreboard and checks every field of every report. Covers short
// and long packets, the field length thresholds, all hand hints, random
// idling on both channels and a long output stall that backs up the input.
// ----------------------------------------------------------------------------
module tb_controller_report_parser_core;

   localparam int PACKET_LIMIT = 96;
   localparam int MAX_GAP      = 13;
   localparam int START_HOLD   = 120;
   localparam int STALL_LIMIT  = 1000;
   localparam int DRAIN_CYCLES = 6;
   localparam int ITEM_TARGET  = 850;
   localparam int PHASE_BYTES  = 120;
   localparam int MAX_REPORTED = 10;

   // Report layout, byte offsets within the packet
   localparam int BTN_AT    = 3;
   localparam int STICK_AT  = 10;
   localparam int MOTION_AT = 16;
   localparam int DIST_AT   = 22;
   localparam int TRIG_AT   = 60;
   localparam int MIN_REPORT_LEN = 7;
   localparam int COUNT_TOP = 127;

   localparam logic [11:0] STICK_CENTER = 12'd2047;
   localparam logic [1:0]  HINT_LEFT    = 2'd1;
   localparam logic [1:0]  HINT_RIGHT   = 2'd2;
   localparam logic [31:0] RIGHT_BUTTONS = 32'h0000FF00 | 32'h00040000 | 32'h00020000 |
                                           32'h00100000 | 32'h00400000;
   localparam logic [31:0] LEFT_BUTTONS  = 32'hFF000000 | 32'h00080000 | 32'h00010000 |
                                           32'h00200000;

   typedef enum {GAP_NONE, GAP_FULL, GAP_SPARSE} gap_mode_type;

   typedef struct packed {
      logic        report_valid;
      logic [31:0] buttons;
      logic [7:0]  trigger_left;
      logic [7:0]  trigger_right;
      logic [11:0] left_stick_x;
      logic [11:0] left_stick_y;
      logic [11:0] right_stick_x;
      logic [11:0] right_stick_y;
      logic [15:0] motion_x;
      logic [15:0] motion_y;
      logic [15:0] motion_distance;
      logic [1:0]  hand_mask;
   } report_type;

   // Packet decoder prediction and report checking
   class report_scoreboard;
      logic [1:0]  side_hint;
      int          byte_count;
      logic [31:0] button_word;
      logic [15:0] trigger_pair;
      logic [47:0] stick_bits;
      logic [47:0] motion_bits;
      report_type  expected_q[$];
      int          errors;

      function new();
         side_hint = '0;
         errors    = 0;
         clear_packet();
      endfunction

      function void clear_packet();
         byte_count   = 0;
         button_word  = '0;
         trigger_pair = '0;
         stick_bits   = '0;
         motion_bits  = '0;
      endfunction

      // Capture one accepted byte; a final byte yields one expected report
      function void note_byte(logic [7:0] b, logic last);
         int         pos;
         int         len;
         report_type r;
         pos = byte_count;
         if (pos < PACKET_LIMIT) begin
            if (pos >= BTN_AT && pos <= BTN_AT + 3)
               button_word[(pos - BTN_AT) * 8 +: 8] = b;
            else if (pos == TRIG_AT || pos == TRIG_AT + 1)
               trigger_pair[(pos - TRIG_AT) * 8 +: 8] = b;
            else if (pos >= STICK_AT && pos <= STICK_AT + 5)
               stick_bits[(pos - STICK_AT) * 8 +: 8] = b;
            else if (pos >= MOTION_AT && pos <= MOTION_AT + 3)
               motion_bits[(pos - MOTION_AT) * 8 +: 8] = b;
            else if (pos == DIST_AT || pos == DIST_AT + 1)
               motion_bits[32 + (pos - DIST_AT) * 8 +: 8] = b;
         end
         // counter saturates
         if (pos < COUNT_TOP)
            byte_count = pos + 1;
         if (!last)
            return;

         len = (pos + 1 > PACKET_LIMIT) ? PACKET_LIMIT : pos + 1;
         r = '0;
         if (len >= MIN_REPORT_LEN) begin
            r.report_valid  = 1'b1;
            r.buttons       = button_word;
            r.left_stick_x  = STICK_CENTER;
            r.left_stick_y  = STICK_CENTER;
            r.right_stick_x = STICK_CENTER;
            r.right_stick_y = STICK_CENTER;
            if (len > TRIG_AT)
               r.trigger_left = trigger_pair[7:0];
            if (len > TRIG_AT + 1)
               r.trigger_right = trigger_pair[15:8];
            if (len >= STICK_AT + 3) begin
               r.left_stick_x = stick_bits[11:0];
               r.left_stick_y = stick_bits[23:12];
            end
            if (len >= STICK_AT + 6) begin
               r.right_stick_x = stick_bits[35:24];
               r.right_stick_y = stick_bits[47:36];
            end
            if (len >= MOTION_AT + 2)
               r.motion_x = motion_bits[15:0];
            if (len >= MOTION_AT + 4)
               r.motion_y = motion_bits[31:16];
            if (len >= DIST_AT + 2)
               r.motion_distance = motion_bits[47:32];
            // hint of three counts as unknown
            r.hand_mask[0] = (side_hint == HINT_LEFT) || ((button_word & LEFT_BUTTONS) != 0);
            r.hand_mask[1] = (side_hint == HINT_RIGHT) || ((button_word & RIGHT_BUTTONS) != 0);
         end
         expected_q.push_back(r);
         clear_packet();
      endfunction

      function void flag(string what, logic [31:0] want, logic [31:0] got);
         errors++;
         if (errors <= MAX_REPORTED)
            $display("%0t mismatch %s: expected 0x%0h, got 0x%0h", $realtime, what, want, got);
      endfunction

      function void compare_field(string what, logic [31:0] want, logic [31:0] got);
         if (want !== got)
            flag(what, want, got);
      endfunction

      function void check_report(report_type got);
         report_type want;
         if (expected_q.size() == 0) begin
            flag("report with none pending", 32'h0, got.buttons);
            return;
         end
         want = expected_q.pop_front();
         compare_field("report_valid", 32'(want.report_valid), 32'(got.report_valid));
         compare_field("buttons", want.buttons, got.buttons);
         compare_field("trigger_left", 32'(want.trigger_left), 32'(got.trigger_left));
         compare_field("trigger_right", 32'(want.trigger_right), 32'(got.trigger_right));
         compare_field("left_stick_x", 32'(want.left_stick_x), 32'(got.left_stick_x));
         compare_field("left_stick_y", 32'(want.left_stick_y), 32'(got.left_stick_y));
         compare_field("right_stick_x", 32'(want.right_stick_x), 32'(got.right_stick_x));
         compare_field("right_stick_y", 32'(want.right_stick_y), 32'(got.right_stick_y));
         compare_field("motion_x", 32'(want.motion_x), 32'(got.motion_x));
         compare_field("motion_y", 32'(want.motion_y), 32'(got.motion_y));
         compare_field("motion_distance", 32'(want.motion_distance),
                       32'(got.motion_distance));
         compare_field("hand_mask", 32'(want.hand_mask), 32'(got.hand_mask));
      endfunction
   endclass

   logic               clock;
   logic               reset          = 1'b1;
   logic               csr_write_en   = 1'b0;
   logic [1:0]         csr_write_data = 2'd0;
   logic               req_valid      = 1'b0;
   logic               req_ready;
   logic [7:0]         req_byte_in    = 8'd0;
   logic               req_last_byte  = 1'b0;
   logic               rsp_valid;
   logic               rsp_ready      = 1'b0;
   logic               rsp_report_valid;
   logic [31:0]        rsp_buttons;
   logic [7:0]         rsp_trigger_left;
   logic [7:0]         rsp_trigger_right;
   logic [11:0]        rsp_left_stick_x;
   logic [11:0]        rsp_left_stick_y;
   logic [11:0]        rsp_right_stick_x;
   logic [11:0]        rsp_right_stick_y;
   logic signed [15:0] rsp_motion_x;
   logic signed [15:0] rsp_motion_y;
   logic signed [15:0] rsp_motion_distance;
   logic [1:0]         rsp_hand_mask;

   report_scoreboard sb = new();
   gap_mode_type send_mode  = GAP_NONE;
   gap_mode_type ready_mode = GAP_NONE;
   int           ready_hold = START_HOLD;
   int           ready_wait = 0;
   int           long_lens[4] = '{130, PACKET_LIMIT + 1, TRIG_AT + 2, TRIG_AT + 1};

   controller_report_parser_core #(
      .MAX_PACKET_BYTES(PACKET_LIMIT)
   ) u_top (
      .clock               (clock),
      .reset               (reset),
      .csr_write_en        (csr_write_en),
      .csr_write_data      (csr_write_data),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_byte_in         (req_byte_in),
      .req_last_byte       (req_last_byte),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_report_valid    (rsp_report_valid),
      .rsp_buttons         (rsp_buttons),
      .rsp_trigger_left    (rsp_trigger_left),
      .rsp_trigger_right   (rsp_trigger_right),
      .rsp_left_stick_x    (rsp_left_stick_x),
      .rsp_left_stick_y    (rsp_left_stick_y),
      .rsp_right_stick_x   (rsp_right_stick_x),
      .rsp_right_stick_y   (rsp_right_stick_y),
      .rsp_motion_x        (rsp_motion_x),
      .rsp_motion_y        (rsp_motion_y),
      .rsp_motion_distance (rsp_motion_distance),
      .rsp_hand_mask       (rsp_hand_mask)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int draw_gap(gap_mode_type mode);
      case (mode)
         GAP_NONE: return 0;
         GAP_FULL: return $urandom_range(0, MAX_GAP);
         default:  return ($urandom_range(0, 7) == 0) ? $urandom_range(1, MAX_GAP) : 0;
      endcase
   endfunction

   // Mostly button words that leave one hand group empty
   function automatic logic [31:0] pick_buttons();
      case ($urandom_range(0, 4))
         0:       return 32'h0;
         1:       return 32'h1 << $urandom_range(0, 31);
         2:       return $urandom() & ~LEFT_BUTTONS;
         3:       return $urandom() & ~RIGHT_BUTTONS;
         default: return $urandom();
      endcase
   endfunction

   // Biased toward the stick and motion extremes
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 7))
         0:       return 8'h00;
         1:       return 8'hFF;
         2:       return 8'h80;
         3:       return 8'h7F;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // Mostly lengths around the field thresholds, some short and long ones
   function automatic int pick_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 15)
         return $urandom_range(1, MIN_REPORT_LEN - 1);
      else if (r < 80)
         return $urandom_range(MIN_REPORT_LEN, DIST_AT + 4);
      else if (r < 95)
         return $urandom_range(DIST_AT + 5, TRIG_AT + 10);
      else
         return $urandom_range(PACKET_LIMIT - 6, COUNT_TOP + 8);
   endfunction

   // One item on the input channel
   task automatic send_byte(input logic [7:0] b, input logic last);
      int gap;
      gap = draw_gap(send_mode);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid     <= 1'b1;
      req_byte_in   <= b;
      req_last_byte <= last;
      do @(posedge clock); while (!req_ready);
      sb.note_byte(b, last);
   endtask

   // Button bytes from a word; other bytes fixed or random
   task automatic send_packet(input int len, input logic [31:0] btn, input bit rand_fill,
                              input logic [7:0] fill);
      int         i;
      logic [7:0] b;
      for (i = 0; i < len; i++) begin
         if (i >= BTN_AT && i <= BTN_AT + 3)
            b = btn[(i - BTN_AT) * 8 +: 8];
         else
            b = rand_fill ? pick_byte() : fill;
         send_byte(b, i == len - 1);
      end
   endtask

   // Stop sending and let every pending report drain
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (sb.expected_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_hint(input logic [1:0] value);
      @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      sb.side_hint = value;
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   // Output ready: long hold-off at start, then per-item random waits
   always @(negedge clock) begin
      if (ready_hold > 0) begin
         rsp_ready <= 1'b0;
         ready_hold--;
      end else if (ready_wait > 0) begin
         rsp_ready <= 1'b0;
         ready_wait--;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Report monitor
   always @(posedge clock) begin
      report_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.report_valid    = rsp_report_valid;
         got.buttons         = rsp_buttons;
         got.trigger_left    = rsp_trigger_left;
         got.trigger_right   = rsp_trigger_right;
         got.left_stick_x    = rsp_left_stick_x;
         got.left_stick_y    = rsp_left_stick_y;
         got.right_stick_x   = rsp_right_stick_x;
         got.right_stick_y   = rsp_right_stick_y;
         got.motion_x        = rsp_motion_x;
         got.motion_y        = rsp_motion_y;
         got.motion_distance = rsp_motion_distance;
         got.hand_mask       = rsp_hand_mask;
         sb.check_report(got);
         ready_wait = draw_gap(ready_mode);
      end
   end

   // Watchdog on cycles with no traffic
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_write_en)
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      int phase;
      int stim_bytes;
      int phase_bytes;
      int len;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: back to back while the output is held, so the input backs up.
      // Single-byte packet, short packet of all ones, minimum valid length
      // with every button, then a packet with no buttons under an unknown hint.
      send_mode = GAP_NONE;
      send_packet(1, 32'h0, 1'b0, 8'h00);
      send_packet(MIN_REPORT_LEN - 1, 32'hFFFFFFFF, 1'b0, 8'hFF);
      send_packet(MIN_REPORT_LEN, 32'hFFFFFFFF, 1'b0, 8'h00);
      send_packet(MIN_REPORT_LEN + 2, 32'h0, 1'b0, 8'hFF);

      // Random phases, each with its own hint and idling style
      stim_bytes = 0;
      phase = 0;
      while (stim_bytes < ITEM_TARGET) begin
         phase++;
         wait_idle();
         write_hint(2'((phase * 3) % 4));
         send_mode   = gap_mode_type'($urandom_range(0, 2));
         ready_mode  = gap_mode_type'($urandom_range(0, 2));
         phase_bytes = 0;
         // long packets: saturated counter, just past the limit, trigger edges
         if (phase <= 4) begin
            len = long_lens[phase - 1];
            send_packet(len, pick_buttons(), 1'b1, 8'h00);
            phase_bytes += len;
         end
         while (phase_bytes < PHASE_BYTES) begin
            len = pick_len();
            send_packet(len, pick_buttons(), 1'b1, 8'h00);
            phase_bytes += len;
         end
         stim_bytes += phase_bytes;
      end

      wait_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.expected_q.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

[controller_report_parser_core.f]
rtl/core/crp_pkg.sv
rtl/core/crp_front.sv
rtl/core/crp_queue.sv
rtl/core/crp_back.sv
rtl/core/controller_report_parser_core.sv
test/tb_controller_report_parser_core.sv
